>>> sv/clp_pkg.sv
`default_nettype none

package clp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int BASE_W      = 5;
    localparam int DIGIT_W     = 5;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0]  CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0]  CH_A_LO    = 8'h61;
    localparam logic [CHAR_W-1:0]  CH_F_LO    = 8'h66;
    localparam logic [CHAR_W-1:0]  CH_A_UP    = 8'h41;
    localparam logic [CHAR_W-1:0]  CH_F_UP    = 8'h46;
    localparam logic [CHAR_W-1:0]  CH_X_LO    = 8'h78;
    localparam logic [CHAR_W-1:0]  CH_X_UP    = 8'h58;
    localparam logic [CHAR_W-1:0]  CH_TEN_OFS = 8'd10;

    localparam logic [DIGIT_W-1:0] BAD_DIGIT  = 5'd16;

    localparam logic [BASE_W-1:0]  BASE_OCT   = 5'd8;
    localparam logic [BASE_W-1:0]  BASE_DEC   = 5'd10;
    localparam logic [BASE_W-1:0]  BASE_HEX   = 5'd16;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic [BASE_W-1:0]      base;
        logic                   error;
    } t_result;

endpackage

`default_nettype wire

>>> sv/clp_in_reg.sv
`default_nettype none

module clp_in_reg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [clp_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                       i_last,
    input  wire logic                       i_out_free,
    output logic                            o_stall,
    output logic                            o_go,
    output logic [clp_pkg::CHAR_W-1:0]      o_char_code,
    output logic                            o_last
);

    logic                       r_valid;
    logic [clp_pkg::CHAR_W-1:0] r_char_code;
    logic                       r_last;
    logic                       accept;

    // a non-final character never needs the result register
    assign o_go        = r_valid && (!r_last || i_out_free);
    assign o_stall     = r_valid && !o_go;
    assign accept      = i_valid && !o_stall;
    assign o_char_code = r_char_code;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_go) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char_code <= i_char_code;
            r_last      <= i_last;
        end
    end

endmodule

`default_nettype wire

>>> sv/clp_core.sv
`default_nettype none

module clp_core #(
    parameter int VALUE_WIDTH = clp_pkg::VALUE_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_go,
    input  wire logic [clp_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                       i_last,
    output clp_pkg::t_result                o_result
);

    localparam int PROD_W = VALUE_WIDTH + 5;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    function automatic logic [clp_pkg::DIGIT_W-1:0] digit_of(
        input logic [clp_pkg::CHAR_W-1:0] c
    );
        logic [clp_pkg::CHAR_W-1:0] d;
        d = clp_pkg::CH_ZERO;
        if (c >= clp_pkg::CH_ZERO && c <= clp_pkg::CH_NINE) begin
            d = c - clp_pkg::CH_ZERO;
        end else if (c >= clp_pkg::CH_A_LO && c <= clp_pkg::CH_F_LO) begin
            d = c - clp_pkg::CH_A_LO + clp_pkg::CH_TEN_OFS;
        end else if (c >= clp_pkg::CH_A_UP && c <= clp_pkg::CH_F_UP) begin
            d = c - clp_pkg::CH_A_UP + clp_pkg::CH_TEN_OFS;
        end else begin
            return clp_pkg::BAD_DIGIT;
        end
        return d[clp_pkg::DIGIT_W-1:0];
    endfunction

    logic [VALUE_WIDTH-1:0]         r_acc;
    t_radix                         r_radix;
    t_phase                         r_phase;
    logic                           r_sticky;

    logic [VALUE_WIDTH-1:0]         n_acc;
    t_radix                         n_radix;
    logic                           n_sticky;
    logic                           take;
    logic                           is_x;
    logic [clp_pkg::DIGIT_W-1:0]    digit;
    logic [clp_pkg::BASE_W-1:0]     base;
    logic [PROD_W-1:0]              acc_ext;
    logic [PROD_W-1:0]              prod;
    logic [PROD_W-1:0]              digit_ext;
    logic [VALUE_WIDTH+clp_pkg::OUT_VALUE_W-1:0] acc_wide;

    assign is_x      = (i_char_code == clp_pkg::CH_X_LO) || (i_char_code == clp_pkg::CH_X_UP);
    assign digit     = digit_of(i_char_code);
    assign acc_ext   = {5'b0, r_acc};
    assign digit_ext = {{(PROD_W-clp_pkg::DIGIT_W){1'b0}}, digit};

    always_comb begin
        n_radix = r_radix;
        take    = 1'b1;
        unique case (r_phase)
            PH_FIRST: begin
                if (!i_last && i_char_code == clp_pkg::CH_ZERO) begin
                    n_radix = RADIX_OCT;
                    take    = 1'b0;
                end else begin
                    n_radix = RADIX_DEC;
                end
            end
            PH_ZERO: begin
                if (is_x) begin
                    n_radix = RADIX_HEX;
                    take    = 1'b0;
                end
            end
            default: begin
                take = 1'b1;
            end
        endcase
    end

    always_comb begin
        unique case (n_radix)
            RADIX_OCT: base = clp_pkg::BASE_OCT;
            RADIX_HEX: base = clp_pkg::BASE_HEX;
            default:   base = clp_pkg::BASE_DEC;
        endcase
    end

    // shift-add multiply by the base
    always_comb begin
        unique case (n_radix)
            RADIX_OCT: prod = (acc_ext << 3) + digit_ext;
            RADIX_HEX: prod = (acc_ext << 4) + digit_ext;
            default:   prod = (acc_ext << 3) + (acc_ext << 1) + digit_ext;
        endcase
    end

    always_comb begin
        n_acc    = r_acc;
        n_sticky = r_sticky;
        if (r_phase == PH_FIRST && !take) begin
            n_acc = '0;
        end else if (take && !r_sticky) begin
            if (digit >= base || prod[PROD_W-1:VALUE_WIDTH] != '0) begin
                n_sticky = 1'b1;
            end else begin
                n_acc = prod[VALUE_WIDTH-1:0];
            end
        end
    end

    assign acc_wide = {{clp_pkg::OUT_VALUE_W{1'b0}}, n_acc};

    always_comb begin
        o_result.value = n_sticky ? '0 : acc_wide[clp_pkg::OUT_VALUE_W-1:0];
        o_result.base  = base;
        o_result.error = n_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_radix  <= RADIX_DEC;
            r_phase  <= PH_FIRST;
            r_sticky <= 1'b0;
        end else if (i_go) begin
            if (i_last) begin
                r_acc    <= '0;
                r_radix  <= RADIX_DEC;
                r_phase  <= PH_FIRST;
                r_sticky <= 1'b0;
            end else begin
                r_acc    <= n_acc;
                r_radix  <= n_radix;
                r_phase  <= (r_phase == PH_FIRST && !take) ? PH_ZERO : PH_DIGITS;
                r_sticky <= n_sticky;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/c_integer_literal_parser.sv
`default_nettype none

// Channel  Direction  Handshake         Payload
// input    in         i_valid/o_stall   i_char_code[7:0], i_last
// result   out        o_valid/i_stall   o_value[31:0], o_base[4:0], o_error
//
// One character per cycle while o_stall is low; a result passes through the input register, then the result register.
// The accumulate step (shift-add by the base plus overflow compare) is combinational,
// between the input register and the state and result registers.
// Reset is synchronous, active low, and returns the parser to the first character.
// A stalled result blocks only the next final character; others keep flowing.

module c_integer_literal_parser #(
    parameter int VALUE_WIDTH = clp_pkg::VALUE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [clp_pkg::CHAR_W-1:0]      i_char_code,
    input  wire logic                            i_last,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [clp_pkg::OUT_VALUE_W-1:0]      o_value,
    output logic [clp_pkg::BASE_W-1:0]           o_base,
    output logic                                 o_error
);

    logic                       go;
    logic [clp_pkg::CHAR_W-1:0] char_code;
    logic                       last;
    logic                       out_free;
    clp_pkg::t_result           result;
    clp_pkg::t_result           r_result;
    logic                       r_out_valid;

    assign out_free = !r_out_valid || !i_stall;

    clp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .i_out_free  (out_free),
        .o_stall     (o_stall),
        .o_go        (go),
        .o_char_code (char_code),
        .o_last      (last)
    );

    clp_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_char_code (char_code),
        .i_last      (last),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= go && last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && go && last) begin
            r_result <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_result.value;
    assign o_base  = r_result.base;
    assign o_error = r_result.error;

endmodule

`default_nettype wire

>>> bench/testbench.sv
`default_nettype none

module testbench;

    localparam int          CHAR_W       = clp_pkg::CHAR_W;
    localparam int          OUT_VALUE_W  = clp_pkg::OUT_VALUE_W;
    localparam int          BASE_W       = clp_pkg::BASE_W;
    localparam int          TARGET_CHARS = 1900;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [63:0] VALUE_MAX    = 64'hFFFF_FFFF;

    typedef enum logic [1:0] {RDX_DEC, RDX_OCT, RDX_HEX} t_radix;
    typedef enum logic [1:0] {PH_FIRST, PH_ZERO, PH_DIGITS} t_phase;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic [CHAR_W-1:0]      i_char_code = '0;
    logic                   i_last      = 1'b0;
    logic                   i_stall     = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [OUT_VALUE_W-1:0] o_value;
    logic [BASE_W-1:0]      o_base;
    logic                   o_error;

    // parser model state
    logic [63:0] acc;
    t_radix      rdx;
    t_phase      phs;
    bit          sticky;

    clp_pkg::t_result  parsed_q[$];
    clp_pkg::t_result  want;
    logic [CHAR_W-1:0] lit_chars[$];
    int                fails       = 0;
    int                total_chars = 0;
    int                cycles      = 0;
    int                burst_left  = 0;
    bit                gaps_on     = 1'b0;
    logic [15:0]       stall_tick  = '0;

    c_integer_literal_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_base      (o_base),
        .o_error     (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0: i_stall <= 1'b0;
            2'd1: i_stall <= 1'($urandom_range(0, 1));
            2'd2: i_stall <= (stall_tick[1:0] != 2'd0);
            default: i_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [BASE_W-1:0] base_value(t_radix r);
        case (r)
            RDX_OCT: return clp_pkg::BASE_OCT;
            RDX_HEX: return clp_pkg::BASE_HEX;
            default: return clp_pkg::BASE_DEC;
        endcase
    endfunction

    function automatic int digit_of(logic [CHAR_W-1:0] c);
        if (c >= clp_pkg::CH_ZERO && c <= clp_pkg::CH_NINE)
            return int'(c - clp_pkg::CH_ZERO);
        if (c >= clp_pkg::CH_A_LO && c <= clp_pkg::CH_F_LO)
            return int'(c - clp_pkg::CH_A_LO) + 10;
        if (c >= clp_pkg::CH_A_UP && c <= clp_pkg::CH_F_UP)
            return int'(c - clp_pkg::CH_A_UP) + 10;
        return int'(clp_pkg::BAD_DIGIT);
    endfunction

    function automatic void clear_parser();
        acc    = '0;
        rdx    = RDX_DEC;
        phs    = PH_FIRST;
        sticky = 1'b0;
    endfunction

    function automatic void take_digit(logic [CHAR_W-1:0] c);
        logic [63:0] b;
        logic [63:0] d;
        if (sticky) return;
        b = 64'(base_value(rdx));
        d = 64'(digit_of(c));
        if (d >= b || acc > (VALUE_MAX - d) / b)
            sticky = 1'b1;
        else
            acc = (acc * b + d) & VALUE_MAX;
    endfunction

    function automatic void parse_char(logic [CHAR_W-1:0] c, logic l);
        clp_pkg::t_result r;
        if (phs == PH_FIRST) begin
            if (!l && c == clp_pkg::CH_ZERO) begin
                rdx = RDX_OCT;
                acc = '0;
                phs = PH_ZERO;
            end else begin
                rdx = RDX_DEC;
                take_digit(c);
                phs = PH_DIGITS;
            end
        end else if (phs == PH_ZERO) begin
            if (c == clp_pkg::CH_X_LO || c == clp_pkg::CH_X_UP)
                rdx = RDX_HEX;
            else
                take_digit(c);
            phs = PH_DIGITS;
        end else begin
            take_digit(c);
        end
        if (!l) return;
        r.value = sticky ? '0 : acc[OUT_VALUE_W-1:0];
        r.base  = base_value(rdx);
        r.error = sticky;
        parsed_q.push_back(r);
        clear_parser();
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (parsed_q.size() == 0) begin
                $display("%0t: result with nothing expected: value %h base %0d error %0b",
                         $time, o_value, o_base, o_error);
                fails++;
            end else begin
                want = parsed_q.pop_front();
                if (o_value !== want.value) begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, want.value, o_value);
                    fails++;
                end
                if (o_base !== want.base) begin
                    $display("%0t: base mismatch, expected %0d actual %0d",
                             $time, want.base, o_base);
                    fails++;
                end
                if (o_error !== want.error) begin
                    $display("%0t: error mismatch, expected %0b actual %0b",
                             $time, want.error, o_error);
                    fails++;
                end
            end
        end
    end

    task automatic push_char(logic [CHAR_W-1:0] c, logic l);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last      <= l;
        do @(posedge i_clk); while (o_stall);
        parse_char(c, l);
        total_chars++;
    endtask

    task automatic pace();
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
                burst_left = $urandom_range(1, 20);
            end
        end
    endtask

    task automatic send_literal();
        for (int i = 0; i < lit_chars.size(); i++) begin
            push_char(lit_chars[i], i == lit_chars.size() - 1);
            pace();
        end
    endtask

    task automatic send_text(string s);
        lit_chars.delete();
        for (int i = 0; i < s.len(); i++)
            lit_chars.push_back(s[i]);
        send_literal();
    endtask

    function automatic void build_literal();
        logic [63:0] v;
        int          kind;
        int          b;
        int          d;
        lit_chars.delete();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 5))
                lit_chars.push_back(CHAR_W'($urandom_range(0, 255)));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 64'($urandom);
            4: v = VALUE_MAX - 64'($urandom_range(0, 20));
            5: v = VALUE_MAX + 64'($urandom_range(1, 20));
            6: v = {$urandom, $urandom} >> $urandom_range(0, 40);
            default: v = 64'($urandom_range(0, 300));
        endcase
        kind = $urandom_range(0, 2);
        b = (kind == 0) ? 10 : (kind == 1) ? 8 : 16;
        if (!(v == 0 && kind == 2 && $urandom_range(0, 1) == 1)) begin
            if (v == 0)
                lit_chars.push_back(clp_pkg::CH_ZERO);
            while (v != 0) begin
                d = int'(v % 64'(b));
                if (d < 10)
                    lit_chars.push_front(clp_pkg::CH_ZERO + CHAR_W'(d));
                else if ($urandom_range(0, 1) == 1)
                    lit_chars.push_front(clp_pkg::CH_A_UP + CHAR_W'(d - 10));
                else
                    lit_chars.push_front(clp_pkg::CH_A_LO + CHAR_W'(d - 10));
                v = v / 64'(b);
            end
            if (kind != 0)
                repeat ($urandom_range(0, 3) / 2) lit_chars.push_front(clp_pkg::CH_ZERO);
        end
        if (kind == 2)
            lit_chars.push_front(($urandom_range(0, 1) == 1) ? clp_pkg::CH_X_UP
                                                              : clp_pkg::CH_X_LO);
        if (kind != 0)
            lit_chars.push_front(clp_pkg::CH_ZERO);
        if ($urandom_range(0, 99) < 12)
            lit_chars[$urandom_range(0, lit_chars.size() - 1)] =
                CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic test_directed();
        gaps_on = 1'b0;
        send_text("0");
        lit_chars = {8'hFF};
        send_literal();
        send_text("0x");
        send_text("0XaF");
        send_text("08");
        send_text("1x");
        send_text("7");
        send_text("0xFFFFFFFFF");
    endtask

    task automatic test_drain_pause();
        gaps_on = 1'b1;
        repeat (10) begin
            build_literal();
            send_literal();
        end
        // hold off until every result is back
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (parsed_q.size() == 0);
        repeat (5) begin
            build_literal();
            send_literal();
        end
    endtask

    task automatic test_back_to_back();
        int stop_at;
        gaps_on = 1'b0;
        stop_at = total_chars + 300;
        while (total_chars < stop_at) begin
            build_literal();
            send_literal();
        end
    endtask

    task automatic test_random_bursts();
        gaps_on = 1'b1;
        while (total_chars < TARGET_CHARS) begin
            build_literal();
            send_literal();
        end
    endtask

    initial begin
        clear_parser();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_drain_pause();
        test_back_to_back();
        test_random_bursts();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (parsed_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
